// ===== sv/aspa_pkg.sv =====
// ----------------------------------------------------------------------------
// ASPA path check package
// Shared types and codes for the customer-to-provider path check unit.
// ----------------------------------------------------------------------------
package aspa_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW       = 6;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_SEG   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] REL_PROV  = 2'd0;
  localparam logic [1:0] REL_CUST  = 2'd1;
  localparam logic [1:0] REL_OTHER = 2'd2;

  localparam logic [1:0] V_VALID   = 2'd0;
  localparam logic [1:0] V_INVALID = 2'd1;
  localparam logic [1:0] V_UNKNOWN = 2'd2;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_PROV = 2'd1;
  localparam logic [1:0] MODE_CUST = 2'd2;
  localparam logic [1:0] MODE_DONE = 2'd3;

  localparam logic [1:0] W_VALID_1 = 2'd0;
  localparam logic [1:0] W_UNK_1   = 2'd1;
  localparam logic [1:0] W_VALID_2 = 2'd2;
  localparam logic [1:0] W_UNK_2   = 2'd3;

  localparam logic [7:0] SEG_SEQ     = 8'd2;
  localparam logic [7:0] SEG_CONFSEQ = 8'd3;

  // Query token that walks down the chain of cells.
  typedef struct packed {
    logic        act;
    logic [31:0] cust;
    logic [31:0] prov;
    logic        seen;
    logic        found;
  } aspa_tok_t;

  // Table write request broadcast to all cells.
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    logic [31:0]     cust;
    logic [31:0]     prov;
    logic            present;
  } aspa_wr_t;

endpackage

// ===== sv/aspa_cell.sv =====
// ----------------------------------------------------------------------------
// ASPA pair cell
// Holds one customer/provider pair and matches the passing query token.
// ----------------------------------------------------------------------------
module aspa_cell
  import aspa_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [IdxW-1:0] cell_idx,
  input  aspa_wr_t        wr,
  input  aspa_tok_t       tok_in,
  output aspa_tok_t       tok_out
);

  logic [31:0] cust_r;
  logic [31:0] prov_r;
  logic        present_r;
  aspa_tok_t   tok_r;
  aspa_tok_t   tok_nxt;
  logic        hit_cust;

  // Slot storage; present bit cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
    end else if (wr.en && wr.idx == cell_idx) begin
      present_r <= wr.present;
    end
    if (wr.en && wr.idx == cell_idx) begin
      cust_r <= wr.cust;
      prov_r <= wr.prov;
    end
  end

  // Match against the token and pass it on.
  assign hit_cust = present_r && (cust_r == tok_in.cust);

  always_comb begin
    tok_nxt       = tok_in;
    tok_nxt.seen  = tok_in.seen | hit_cust;
    tok_nxt.found = tok_in.found | (hit_cust && prov_r == tok_in.prov);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.act <= 1'b0;
    end else begin
      tok_r.act <= tok_in.act;
    end
    tok_r.cust  <= tok_nxt.cust;
    tok_r.prov  <= tok_nxt.prov;
    tok_r.seen  <= tok_nxt.seen;
    tok_r.found <= tok_nxt.found;
  end

  assign tok_out = tok_r;

endmodule

// ===== sv/aspa_chain.sv =====
// ----------------------------------------------------------------------------
// ASPA cell chain
// Row of pair cells; a lookup token enters at cell zero and leaves at the end.
// ----------------------------------------------------------------------------
module aspa_chain
  import aspa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  aspa_wr_t  wr,
  input  aspa_tok_t tok_in,
  output aspa_tok_t tok_out
);

  aspa_tok_t link [TableDepth+1];

  assign link[0] = tok_in;

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    aspa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_idx(IdxW'(g)),
      .wr      (wr),
      .tok_in  (link[g]),
      .tok_out (link[g+1])
    );
  end

  assign tok_out = link[TableDepth];

endmodule

// ===== sv/as_path_customer_provider_check_unit.sv =====
// ----------------------------------------------------------------------------
// AS path customer-to-provider check unit
// Verifies AS paths segment by segment against a table of authorized pairs.
// ----------------------------------------------------------------------------
// Channel | Dir | Contents
// in_     | in  | operation, table entry, start and segment fields
// out_    | out | verdict, final_res
//
// A table write gives no result.
// A start, or a segment that needs no lookup, goes from ST_IDLE straight to ST_OUT.
// A segment with a lookup waits in ST_LOOK while the token walks all 64 cells.
// One item is handled at a time; in_tready is low while a result is pending.
// Synchronous active-low reset clears the table present bits and walk state.
// ----------------------------------------------------------------------------
module as_path_customer_provider_check_unit
  import aspa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[1:0], entry_index[7:2], entry_customer_asn[39:8],
  // entry_provider_asn[71:40], entry_valid[72], relation[74:73],
  // local_asn[106:75], segment_type[114:107], segment_count[122:115],
  // segment_last_asn[154:123], zero fill [159:155]
  input  logic [159:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // verdict[1:0], final_res[2], zero fill [7:3]
  output logic [7:0]   out_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [1:0]  mode_r, walk_r, rv_r;
  logic [31:0] prev_r;
  logic [1:0]  res_v_r;
  logic        res_f_r;
  logic        last_r;

  logic [1:0]  op, rel;
  logic [7:0]  seg_type, seg_count;
  logic [31:0] last_asn;
  logic        acc;

  aspa_wr_t  wr;
  aspa_tok_t tok_in, tok_out;
  logic [1:0] hop;

  assign op        = in_tdata[1:0];
  assign rel       = in_tdata[74:73];
  assign seg_type  = in_tdata[114:107];
  assign seg_count = in_tdata[122:115];
  assign last_asn  = in_tdata[154:123];

  assign in_tready = (st_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;

  // Table writes go straight to the cells.
  assign wr.en      = acc && op == OP_WRITE;
  assign wr.idx     = in_tdata[7:2];
  assign wr.cust    = in_tdata[39:8];
  assign wr.prov    = in_tdata[71:40];
  assign wr.present = in_tdata[72];

  // Lookup token for a segment that needs a hop check.
  logic need_look;
  assign need_look = acc && op == OP_SEG && (mode_r == MODE_PROV || mode_r == MODE_CUST)
                     && seg_count != 8'd0 && (seg_type == SEG_SEQ || seg_type == SEG_CONFSEQ);

  assign tok_in.act   = need_look;
  assign tok_in.cust  = prev_r;
  assign tok_in.prov  = last_asn;
  assign tok_in.seen  = 1'b0;
  assign tok_in.found = 1'b0;

  aspa_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .tok_in (tok_in),
    .tok_out(tok_out)
  );

  assign hop = tok_out.found ? V_VALID : (tok_out.seen ? V_INVALID : V_UNKNOWN);

  always_comb begin
    unique case (st_r)
      ST_IDLE: begin
        if (need_look) st_nxt = ST_LOOK;
        else if (acc && (op == OP_START || op == OP_SEG)) st_nxt = ST_OUT;
        else st_nxt = ST_IDLE;
      end
      ST_LOOK: st_nxt = tok_out.act ? ST_OUT : ST_LOOK;
      ST_OUT:  st_nxt = out_tready ? ST_IDLE : ST_OUT;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Path state and result register.
  always_ff @(posedge clk) begin
    logic [1:0] w;
    logic [1:0] v;
    logic       bad;
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      mode_r <= MODE_IDLE;
      walk_r <= W_VALID_1;
      rv_r   <= V_VALID;
      prev_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (acc && op == OP_START) begin
        walk_r  <= W_VALID_1;
        prev_r  <= in_tdata[106:75];
        res_f_r <= 1'b1;
        if (rel != REL_PROV && rel != REL_CUST) begin
          mode_r <= MODE_DONE; rv_r <= V_UNKNOWN; res_v_r <= V_UNKNOWN;
        end else begin
          rv_r    <= V_VALID;
          res_v_r <= V_VALID;
          res_f_r <= in_tlast;
          if (in_tlast) mode_r <= MODE_DONE;
          else mode_r <= (rel == REL_PROV) ? MODE_PROV : MODE_CUST;
        end
      end else if (acc && op == OP_SEG && !need_look) begin
        res_f_r <= 1'b1;
        if (mode_r == MODE_IDLE) begin
          res_v_r <= V_UNKNOWN;
        end else if (mode_r == MODE_DONE) begin
          res_v_r <= rv_r;
        end else begin
          v = (seg_count == 8'd0 && mode_r == MODE_CUST) ? rv_r : V_UNKNOWN;
          mode_r <= MODE_DONE; rv_r <= v; res_v_r <= v;
        end
      end else if (need_look) begin
        prev_r <= last_asn;
        last_r <= in_tlast;
      end else if (st_r == ST_LOOK && tok_out.act) begin
        w   = walk_r;
        bad = 1'b0;
        v   = rv_r;
        if (mode_r == MODE_CUST) begin
          if (hop == V_INVALID) bad = 1'b1;
          else if (hop == V_UNKNOWN) v = V_UNKNOWN;
        end else begin
          unique case (walk_r)
            W_VALID_1: begin
              if (hop == V_UNKNOWN) w = W_UNK_1;
              else if (hop == V_INVALID) w = W_VALID_2;
            end
            W_UNK_1: if (hop == V_INVALID) w = W_UNK_2;
            W_VALID_2: begin
              if (hop == V_INVALID) bad = 1'b1;
              else if (hop == V_UNKNOWN) w = W_UNK_2;
            end
            default: if (hop == V_INVALID) bad = 1'b1;
          endcase
          v = (w == W_VALID_1 || w == W_VALID_2) ? V_VALID : V_UNKNOWN;
        end
        if (bad) begin
          mode_r <= MODE_DONE; rv_r <= V_INVALID; res_v_r <= V_INVALID; res_f_r <= 1'b1;
        end else begin
          walk_r  <= w;
          rv_r    <= v;
          res_v_r <= v;
          res_f_r <= last_r;
          if (last_r) mode_r <= MODE_DONE;
        end
      end
    end
  end

  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata  = {5'd0, res_f_r, res_v_r};

  // The chain returns exactly one token per lookup, only while waiting.
  a_tok_state: assert property (@(posedge clk) disable iff (!rst_n)
    tok_out.act |-> st_r == ST_LOOK) else $error("token outside lookup");
  a_look_entry: assert property (@(posedge clk) disable iff (!rst_n)
    need_look |=> st_r == ST_LOOK) else $error("lookup not entered");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");

endmodule
